/* src/flp_pkg.sv */
// ----------------------------------------------------------------------------
// flp_pkg
// Function codes, status codes and constants of the free list pool.
// ----------------------------------------------------------------------------
`default_nettype none
package flp_pkg;
  localparam logic [2:0] FUNC_ALLOC     = 3'd0;
  localparam logic [2:0] FUNC_DELETE    = 3'd1;
  localparam logic [2:0] FUNC_WR_PEN    = 3'd2;
  localparam logic [2:0] FUNC_WR_VEL    = 3'd3;
  localparam logic [2:0] FUNC_MAX_PEN   = 3'd4;
  localparam logic [2:0] FUNC_MAX_VEL   = 3'd5;
  localparam logic [2:0] FUNC_RESET     = 3'd6;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_FULL        = 2'd1;
  localparam logic [1:0] ST_NOT_ACTIVE  = 2'd2;
  localparam logic [1:0] ST_EMPTY       = 2'd3;

  localparam logic signed [31:0] KEY_MINUS_ONE = -32'sd65536;
endpackage
`default_nettype wire

/* src/free_list_pool_with_max_search.sv */
// ----------------------------------------------------------------------------
// free_list_pool_with_max_search
// Node pool with a free list, a doubly linked active list and max-key search.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive func, node_id and key_value with start high while
//   busy is low; that edge accepts the transaction. busy then stays high
//   until the result is shown.
//   Result channel: result_node, result_key, status and active_count are valid
//   for exactly one cycle while done is high. The receiver cannot stall.
//   Memories: link state lives in synchronous memories with registered reads.
//   A max query reads each active node in turn. A list reset unlinks each
//   active node as a delete. done rises in the first cycle with busy low.
//   Reset: a clearing pass walks all CAPACITY entries, one per cycle, and
//   rebuilds the free list 0,1,2,...; busy is high until the pass ends. Key
//   memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module free_list_pool_with_max_search #(
  parameter int CAPACITY = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         func,
  input  wire logic [5:0]         node_id,
  input  wire logic signed [31:0] key_value,
  output logic                    done,
  output logic [5:0]              result_node,
  output logic signed [31:0]      result_key,
  output logic [1:0]              status,
  output logic [6:0]              active_count
);
  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;  // read links of cur
  localparam logic [3:0] S_ALLOC  = 4'd3;  // got next of free head
  localparam logic [3:0] S_DEL    = 4'd4;  // got prev/next of cur
  localparam logic [3:0] S_DEL2   = 4'd5;  // patch neighbor prev
  localparam logic [3:0] S_QRD    = 4'd6;  // query read issued
  localparam logic [3:0] S_QCMP   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;
  localparam logic [3:0] S_ACT    = 4'd9;  // got active flag

  // link, flag and key memories
  logic [LW-1:0] next_mem [CAPACITY];
  logic [LW-1:0] prev_mem [CAPACITY];
  logic          act_mem  [CAPACITY];
  logic [31:0]   pen_mem  [CAPACITY];
  logic [31:0]   vel_mem  [CAPACITY];

  logic [3:0]    state;
  logic [AW-1:0] init_idx;
  logic [LW-1:0] active_head, free_head;
  logic [CW-1:0] node_count;
  logic [2:0]    op;
  logic [31:0]   op_key;
  logic [AW-1:0] cur;
  logic [LW-1:0] walk, best;
  logic signed [31:0] maxv;
  logic [LW-1:0] rd_next, rd_prev;
  logic          rd_act;
  logic [31:0]   rd_pen, rd_vel;
  logic [LW-1:0] del_n;

  logic          result_node_hold_v;
  logic [AW-1:0] hold_prev_addr;
  logic [1:0]    st;
  // key of the head, kept for the case that no key exceeds KEY_MINUS_ONE (-65536)
  logic signed [31:0] best_key;

  // memory ports: one address for all reads, writes issued by the sequencer
  logic [AW-1:0] rd_addr;
  logic          we_next, we_prev, we_act, we_pen, we_vel;
  logic [AW-1:0] wa_next, wa_prev, wa_act, wa_key;
  logic [LW-1:0] wd_next, wd_prev;
  logic          wd_act;

  always_ff @(posedge clk) begin
    rd_next <= next_mem[rd_addr];
    rd_prev <= prev_mem[rd_addr];
    rd_act  <= act_mem[rd_addr];
    rd_pen  <= pen_mem[rd_addr];
    rd_vel  <= vel_mem[rd_addr];
    if (we_next) next_mem[wa_next] <= wd_next;
    if (we_prev) prev_mem[wa_prev] <= wd_prev;
    if (we_act)  act_mem[wa_act]   <= wd_act;
    if (we_pen)  pen_mem[wa_key]   <= op_key;
    if (we_vel)  vel_mem[wa_key]   <= op_key;
  end

  logic signed [31:0] qkey;
  logic               is_query;
  assign qkey  = (op == flp_pkg::FUNC_MAX_PEN) ? $signed(rd_pen) : $signed(rd_vel);
  assign is_query = (op == flp_pkg::FUNC_MAX_PEN) || (op == flp_pkg::FUNC_MAX_VEL);
  assign busy  = (state != S_IDLE);

  always_comb begin
    rd_addr = cur;
    we_next = 1'b0; we_prev = 1'b0; we_act = 1'b0; we_pen = 1'b0; we_vel = 1'b0;
    wa_next = cur; wa_prev = cur; wa_act = cur; wa_key = cur;
    wd_next = NIL; wd_prev = NIL; wd_act = 1'b0;
    case (state)
      S_INIT: begin
        we_next = 1'b1; we_prev = 1'b1; we_act = 1'b1; wa_next = init_idx;
        wa_prev = init_idx; wa_act = init_idx; wd_next = LW'(init_idx) + 1'b1;
      end
      S_ALLOC: begin
        // pop free head, push at active head
        we_act = 1'b1; wd_act = 1'b1;
        we_prev = 1'b1; wd_prev = NIL;
        we_next = 1'b1; wd_next = active_head;
      end
      S_ACT: begin
        if (rd_act && (op == flp_pkg::FUNC_WR_PEN)) we_pen = 1'b1;
        if (rd_act && (op == flp_pkg::FUNC_WR_VEL)) we_vel = 1'b1;
      end
      S_DEL: begin
        // unlink: fix prev's next, free this node
        if (rd_prev != NIL) begin
          we_next = 1'b1; wa_next = rd_prev[AW-1:0]; wd_next = rd_next;
        end
        we_act = 1'b1; wd_act = 1'b0;
        we_prev = 1'b1; wd_prev = NIL;
      end
      S_DEL2: begin
        if (del_n != NIL) begin
          we_prev = 1'b1; wa_prev = del_n[AW-1:0]; wd_prev = rd_prev;
        end
        we_next = 1'b1; wd_next = free_head;
      end
      S_QRD: rd_addr = walk[AW-1:0];
      default: ;
    endcase
    // allocate: fix the old head's prev link
    if (state == S_DONE && op == flp_pkg::FUNC_ALLOC && result_node_hold_v) begin
      we_prev = 1'b1; wa_prev = hold_prev_addr; wd_prev = LW'(cur);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      state <= S_INIT; init_idx <= '0; active_head <= NIL; free_head <= '0;
      node_count <= '0; result_node_hold_v <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      case (state)
        S_INIT: begin
          init_idx <= init_idx + 1'b1;
          if (32'(init_idx) == CAPACITY - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          result_node_hold_v <= 1'b0;
          if (start) begin
            op <= func; op_key <= key_value;
            maxv <= flp_pkg::KEY_MINUS_ONE;
            case (func)
              flp_pkg::FUNC_ALLOC: begin
                if (free_head == NIL) begin
                  st <= flp_pkg::ST_FULL; state <= S_DONE;
                end else begin
                  st <= flp_pkg::ST_OK; cur <= free_head[AW-1:0]; state <= S_RD;
                end
              end
              flp_pkg::FUNC_DELETE, flp_pkg::FUNC_WR_PEN, flp_pkg::FUNC_WR_VEL: begin
                if (32'(node_id) < CAPACITY) begin
                  st <= flp_pkg::ST_OK; cur <= node_id[AW-1:0]; state <= S_RD;
                end else begin
                  st <= flp_pkg::ST_NOT_ACTIVE; state <= S_DONE;
                end
              end
              flp_pkg::FUNC_MAX_PEN, flp_pkg::FUNC_MAX_VEL: begin
                if (active_head == NIL) begin
                  st <= flp_pkg::ST_EMPTY; state <= S_DONE;
                end else begin
                  st <= flp_pkg::ST_OK;
                  walk <= active_head; best <= active_head; state <= S_QRD;
                end
              end
              flp_pkg::FUNC_RESET: begin
                st <= flp_pkg::ST_OK;
                if (active_head == NIL) state <= S_DONE;
                else begin
                  cur <= active_head[AW-1:0]; state <= S_RD;
                end
              end
              default: begin
                st <= flp_pkg::ST_OK; state <= S_DONE;
              end
            endcase
          end
        end
        S_RD: begin
          case (op)
            flp_pkg::FUNC_ALLOC: state <= S_ALLOC;
            flp_pkg::FUNC_RESET: state <= S_DEL;
            default:             state <= S_ACT;
          endcase
        end
        S_ACT: begin
          if (!rd_act) begin
            st <= flp_pkg::ST_NOT_ACTIVE; state <= S_DONE;
          end else if (op == flp_pkg::FUNC_DELETE) state <= S_DEL;
          else state <= S_DONE;
        end
        S_ALLOC: begin
          free_head <= rd_next;
          result_node_hold_v <= (active_head != NIL);
          hold_prev_addr <= active_head[AW-1:0];
          active_head <= LW'(cur);
          node_count <= node_count + 1'b1;
          state <= S_DONE;
        end
        S_DEL: begin
          if (rd_prev == NIL) active_head <= rd_next;
          del_n <= rd_next;
          state <= S_DEL2;
        end
        S_DEL2: begin
          free_head <= LW'(cur);
          if (node_count != '0) node_count <= node_count - 1'b1;
          if (op == flp_pkg::FUNC_RESET && del_n != NIL) begin
            cur <= del_n[AW-1:0]; state <= S_RD;
          end else state <= S_DONE;
        end
        S_QRD: state <= S_QCMP;
        S_QCMP: begin
          if (qkey > maxv) begin
            maxv <= qkey; best <= walk;
          end
          if (rd_next == NIL) state <= S_DONE;
          else begin
            walk <= rd_next; state <= S_QRD;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
          status <= st;
          active_count <= 7'(node_count);
          result_node <= (op == flp_pkg::FUNC_ALLOC && st == flp_pkg::ST_OK) ? 6'(cur) :
                         (is_query && st == flp_pkg::ST_OK) ? 6'(best) : '0;
          result_key  <= (is_query && st == flp_pkg::ST_OK) ?
                         ((maxv > flp_pkg::KEY_MINUS_ONE) ? maxv : best_key) : '0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_QCMP && walk == active_head) best_key <= qkey;
  end
endmodule
`default_nettype wire
